// File: rtl/core/drfst_pkg.sv
// Package for the dual-rate fixed-step ticker.
// Holds widths, register indexes, result kinds, ALU ops, FSM states and the config struct.
// No dependencies.
package drfst_pkg;

    localparam int DEF_MAX_GAME_STEPS = 8;
    localparam int DEF_MAX_NET_STEPS  = 4;

    localparam int ACC_W    = 40;
    localparam int PERIOD_W = 32;
    localparam int TICK_W   = 32;
    localparam int ALPHA_W  = 17;
    localparam int DIV_BITS = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [ACC_W-1:0]   ACC_MAX = {ACC_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [PERIOD_W-1:0] RST_GAME_PERIOD = 32'd16666667;
    localparam logic [PERIOD_W-1:0] RST_NET_PERIOD  = 32'd33333333;

    typedef enum logic [1:0] {
        REG_GAME_PERIOD = 2'd0,
        REG_NET_PERIOD  = 2'd1,
        REG_LOCK        = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_GAME = 2'd0,
        KIND_NET  = 2'd1,
        KIND_SUM  = 2'd2
    } t_kind;

    typedef enum logic {
        ALU_ADD_SAT = 1'b0,
        ALU_SUB_GE  = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GADD,
        S_GSTEP,
        S_DIV,
        S_RAW,
        S_NADD,
        S_NSTEP,
        S_SUM
    } t_state;

    typedef struct packed {
        logic [PERIOD_W-1:0] game_period;
        logic [PERIOD_W-1:0] net_period;
        logic                lock;
    } t_cfg;

endpackage

// File: rtl/core/drfst_cfg.sv
// APB-style configuration registers: game period, net period, lock mode.
// Depends on drfst_pkg.
module drfst_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [drfst_pkg::ADDR_W-1:0] paddr,
    input  logic [drfst_pkg::DATA_W-1:0] pwdata,
    output logic [drfst_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output drfst_pkg::t_cfg             o_cfg
);
    import drfst_pkg::*;

    logic [PERIOD_W-1:0] r_game_period;
    logic [PERIOD_W-1:0] r_net_period;
    logic                r_lock;
    logic                wr_en;
    t_reg_idx            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_game_period <= RST_GAME_PERIOD;
            r_net_period  <= RST_NET_PERIOD;
            r_lock        <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GAME_PERIOD: r_game_period <= pwdata;
                REG_NET_PERIOD:  r_net_period  <= pwdata;
                REG_LOCK:        r_lock        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAME_PERIOD: prdata = r_game_period;
            REG_NET_PERIOD:  prdata = r_net_period;
            REG_LOCK:        prdata = {{(DATA_W-1){1'b0}}, r_lock};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.game_period = r_game_period;
    assign o_cfg.net_period  = r_net_period;
    assign o_cfg.lock        = r_lock;

endmodule

// File: rtl/core/drfst_alu.sv
// Shared 40-bit arithmetic unit: saturating add, or conditional subtract with compare.
// Depends on drfst_pkg.
module drfst_alu (
    input  drfst_pkg::t_alu_op           i_op,
    input  logic [drfst_pkg::ACC_W-1:0]  i_a,
    input  logic [drfst_pkg::ACC_W-1:0]  i_b,
    output logic [drfst_pkg::ACC_W-1:0]  o_res,
    output logic                         o_ge
);
    import drfst_pkg::*;

    logic [ACC_W:0] sum;
    logic [ACC_W:0] diff;

    assign sum  = {1'b0, i_a} + {1'b0, i_b};
    assign diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = !diff[ACC_W];

    always_comb begin
        unique case (i_op)
            ALU_ADD_SAT: o_res = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            ALU_SUB_GE:  o_res = o_ge ? diff[ACC_W-1:0] : i_a;
            default:     o_res = i_a;
        endcase
    end

endmodule

// File: rtl/core/drfst_core.sv
// Sequencer and state for the ticker: accumulators, counters, serial alpha divide,
// result register. Depends on drfst_pkg and drfst_alu.
module drfst_core #(
    parameter int MAX_GAME_STEPS = drfst_pkg::DEF_MAX_GAME_STEPS,
    parameter int MAX_NET_STEPS  = drfst_pkg::DEF_MAX_NET_STEPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  drfst_pkg::t_cfg                 i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [drfst_pkg::PERIOD_W-1:0]  i_delta_ns,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_event_kind,
    output logic [drfst_pkg::PERIOD_W-1:0]  o_step_ns,
    output logic [drfst_pkg::TICK_W-1:0]    o_tick_index,
    output logic [drfst_pkg::ALPHA_W-1:0]   o_alpha_q16,
    output logic                            o_last
);
    import drfst_pkg::*;

    localparam int MAX_STEPS = (MAX_GAME_STEPS > MAX_NET_STEPS) ? MAX_GAME_STEPS
                                                                : MAX_NET_STEPS;
    localparam int MAX_CNT   = (MAX_STEPS > DIV_BITS) ? MAX_STEPS : DIV_BITS;
    localparam int CNT_W     = $clog2(MAX_CNT + 1);

    t_state               r_state, n_state;
    logic [ACC_W-1:0]     r_game_accum;
    logic [ACC_W-1:0]     r_net_accum;
    logic [TICK_W-1:0]    r_game_ticks;
    logic [TICK_W-1:0]    r_net_ticks;
    logic [ALPHA_W-1:0]   r_alpha;
    logic [PERIOD_W-1:0]  r_rem;
    logic [DIV_BITS-2:0]  r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [PERIOD_W-1:0]  r_delta;

    logic                 r_ov;
    t_kind                r_kind;
    logic [PERIOD_W-1:0]  r_step;
    logic [TICK_W-1:0]    r_idx;
    logic [ALPHA_W-1:0]   r_oalpha;
    logic                 r_last;

    t_alu_op              alu_op;
    logic [ACC_W-1:0]     alu_a, alu_b, alu_res;
    logic                 alu_ge;

    logic                 in_acc;
    logic                 out_free;
    logic                 periods_ok;
    logic                 game_more, net_more;
    logic                 div_done;
    logic                 emit;
    t_kind                emit_kind;
    logic [PERIOD_W-1:0]  emit_step;
    logic [TICK_W-1:0]    emit_idx;
    logic [ALPHA_W-1:0]   emit_alpha;

    drfst_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_ge  (alu_ge)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;
    assign periods_ok = (i_cfg.game_period != '0) && (i_cfg.net_period != '0);
    assign game_more  = (r_cnt < CNT_W'(MAX_GAME_STEPS)) && alu_ge;
    assign net_more   = (r_cnt < CNT_W'(MAX_NET_STEPS)) && alu_ge;
    assign div_done   = (r_cnt == CNT_W'(DIV_BITS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!periods_ok)      n_state = S_SUM;
                    else if (i_cfg.lock)  n_state = S_GADD;
                    else                  n_state = S_RAW;
                end
            end
            S_GADD:  n_state = S_GSTEP;
            S_GSTEP: begin
                if (!game_more)           n_state = alu_ge ? S_NADD : S_DIV;
            end
            S_DIV: begin
                if (div_done)             n_state = S_NADD;
            end
            S_RAW: begin
                if (out_free)             n_state = S_NADD;
            end
            S_NADD:  n_state = S_NSTEP;
            S_NSTEP: begin
                if (!net_more)            n_state = S_SUM;
            end
            S_SUM: begin
                if (out_free)             n_state = S_IDLE;
            end
            default:                      n_state = S_IDLE;
        endcase
    end

    // ALU operand selection and result emission
    always_comb begin
        alu_op     = ALU_SUB_GE;
        alu_a      = r_game_accum;
        alu_b      = {{(ACC_W-PERIOD_W){1'b0}}, i_cfg.game_period};
        emit       = 1'b0;
        emit_kind  = KIND_GAME;
        emit_step  = i_cfg.game_period;
        emit_idx   = r_game_ticks + TICK_W'(1);
        emit_alpha = '0;
        unique case (r_state)
            S_GADD: begin
                alu_op = ALU_ADD_SAT;
                alu_b  = {{(ACC_W-PERIOD_W){1'b0}}, r_delta};
            end
            S_GSTEP: begin
                emit = game_more && out_free;
            end
            S_DIV: begin
                alu_a = {{(ACC_W-PERIOD_W-1){1'b0}}, r_rem, 1'b0};
            end
            S_RAW: begin
                emit      = out_free;
                emit_step = r_delta;
            end
            S_NADD: begin
                alu_op = ALU_ADD_SAT;
                alu_a  = r_net_accum;
                alu_b  = {{(ACC_W-PERIOD_W){1'b0}}, r_delta};
            end
            S_NSTEP: begin
                alu_a     = r_net_accum;
                alu_b     = {{(ACC_W-PERIOD_W){1'b0}}, i_cfg.net_period};
                emit      = net_more && out_free;
                emit_kind = KIND_NET;
                emit_step = i_cfg.net_period;
                emit_idx  = r_net_ticks + TICK_W'(1);
            end
            S_SUM: begin
                emit       = out_free;
                emit_kind  = KIND_SUM;
                emit_step  = '0;
                emit_idx   = r_game_ticks;
                emit_alpha = r_alpha;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_game_accum <= '0;
            r_net_accum  <= '0;
            r_game_ticks <= '0;
            r_net_ticks  <= '0;
            r_alpha      <= '0;
            r_cnt        <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_GADD: begin
                    r_game_accum <= alu_res;
                    r_cnt        <= '0;
                end
                S_GSTEP: begin
                    if (emit) begin
                        r_game_accum <= alu_res;
                        r_game_ticks <= emit_idx;
                        r_cnt        <= r_cnt + CNT_W'(1);
                    end else if (!game_more) begin
                        if (alu_ge) begin
                            r_alpha <= ONE_Q16;
                        end
                        r_rem <= r_game_accum[PERIOD_W-1:0];
                        r_cnt <= '0;
                    end
                end
                S_DIV: begin
                    r_rem <= alu_res[PERIOD_W-1:0];
                    r_quo <= {r_quo[DIV_BITS-3:0], alu_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (div_done) begin
                        r_alpha <= {1'b0, r_quo, alu_ge};
                    end
                end
                S_RAW: begin
                    if (emit) begin
                        r_game_ticks <= emit_idx;
                        r_alpha      <= ONE_Q16;
                    end
                end
                S_NADD: begin
                    r_net_accum <= alu_res;
                    r_cnt       <= '0;
                end
                S_NSTEP: begin
                    if (emit) begin
                        r_net_accum <= alu_res;
                        r_net_ticks <= emit_idx;
                        r_cnt       <= r_cnt + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_delta <= i_delta_ns;
        end
        if (emit) begin
            r_kind   <= emit_kind;
            r_step   <= emit_step;
            r_idx    <= emit_idx;
            r_oalpha <= emit_alpha;
            r_last   <= (emit_kind == KIND_SUM);
        end
    end

    assign o_out_valid  = r_ov;
    assign o_event_kind = r_kind;
    assign o_step_ns    = r_step;
    assign o_tick_index = r_idx;
    assign o_alpha_q16  = r_oalpha;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_div_rem_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({8'd0, r_rem} < {8'd0, i_cfg.game_period}))
        else $error("divide remainder not below game period");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alpha <= ONE_Q16)
        else $error("alpha above one");

    a_game_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GSTEP) |-> (r_cnt <= CNT_W'(MAX_GAME_STEPS)))
        else $error("game step count over limit");

    a_net_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NSTEP) |-> (r_cnt <= CNT_W'(MAX_NET_STEPS)))
        else $error("net step count over limit");

    a_sum_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (emit_kind == KIND_SUM)) |=> (r_state == S_IDLE) && r_last)
        else $error("summary did not close the run");
`endif

endmodule

// File: rtl/core/dual_rate_fixed_step_ticker_unit.sv
// Locked mode: an input runs game add, game ticks, the serial alpha divide, net add, net
// ticks and summary; the divide is skipped when the game step cap leaves a full period.
// Unlocked: one raw game tick, net add, net ticks, summary; zero period: summary only.
// A new input waits for idle; ticks go one per cycle via the shared 40-bit ALU unless stalled.
// Reset (synchronous, active low) clears accumulators, counters and alpha, loads default
// periods and lock mode.
module dual_rate_fixed_step_ticker_unit #(
    parameter int MAX_GAME_STEPS = drfst_pkg::DEF_MAX_GAME_STEPS,
    parameter int MAX_NET_STEPS  = drfst_pkg::DEF_MAX_NET_STEPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [drfst_pkg::ADDR_W-1:0]    paddr,
    input  logic [drfst_pkg::DATA_W-1:0]    pwdata,
    output logic [drfst_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [drfst_pkg::PERIOD_W-1:0]  i_delta_ns,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_event_kind,
    output logic [drfst_pkg::PERIOD_W-1:0]  o_step_ns,
    output logic [drfst_pkg::TICK_W-1:0]    o_tick_index,
    output logic [drfst_pkg::ALPHA_W-1:0]   o_alpha_q16,
    output logic                            o_last
);
    import drfst_pkg::*;

    t_cfg cfg;

    drfst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    drfst_core #(
        .MAX_GAME_STEPS (MAX_GAME_STEPS),
        .MAX_NET_STEPS  (MAX_NET_STEPS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_delta_ns   (i_delta_ns),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_kind (o_event_kind),
        .o_step_ns    (o_step_ns),
        .o_tick_index (o_tick_index),
        .o_alpha_q16  (o_alpha_q16),
        .o_last       (o_last)
    );

endmodule
